/* rtl/shcr_pkg.sv */
// package with shared types and constants of the crossfeed reverb block
`timescale 1ns / 1ps
`default_nettype none
package shcr_pkg;

    localparam int W_TAP_ONE   = 40632;
    localparam int W_TAP_TWO   = 31457;
    localparam int W_TAP_THREE = 22282;

    localparam logic [2:0] REG_CROSS    = 3'd0;
    localparam logic [2:0] REG_ROOM     = 3'd1;
    localparam logic [2:0] REG_WIDTH    = 3'd2;
    localparam logic [2:0] REG_FEEDBACK = 3'd3;
    localparam logic [2:0] REG_SHADOW   = 3'd4;
    localparam logic [2:0] REG_DAMP     = 3'd5;
    localparam logic [2:0] REG_TRIM     = 3'd6;

    typedef struct packed {
        logic [15:0] cross_gain;
        logic [15:0] room_gain;
        logic [15:0] width_gain;
        logic [14:0] feedback_gain;
        logic [15:0] shadow_coef;
        logic [15:0] damp_coef;
        logic [16:0] out_trim;
    } shcr_cfg_t;

endpackage
`default_nettype wire

/* rtl/shcr_regs.sv */
// configuration register file on an apb-style port
`timescale 1ns / 1ps
`default_nettype none
module shcr_regs
    import shcr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output shcr_cfg_t        cfg
);
    shcr_cfg_t cfg_reg;
    logic [2:0] idx;

    assign idx = paddr[4:2];
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cross_gain    <= '0;
            cfg_reg.room_gain     <= '0;
            cfg_reg.width_gain    <= 16'd16384;
            cfg_reg.feedback_gain <= '0;
            cfg_reg.shadow_coef   <= 16'd8796;
            cfg_reg.damp_coef     <= 16'd24086;
            cfg_reg.out_trim      <= 17'd65536;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_CROSS:    cfg_reg.cross_gain    <= pwdata[15:0];
                REG_ROOM:     cfg_reg.room_gain     <= pwdata[15:0];
                REG_WIDTH:    cfg_reg.width_gain    <= pwdata[15:0];
                REG_FEEDBACK: cfg_reg.feedback_gain <= pwdata[14:0];
                REG_SHADOW:   cfg_reg.shadow_coef   <= pwdata[15:0];
                REG_DAMP:     cfg_reg.damp_coef     <= pwdata[15:0];
                REG_TRIM:     cfg_reg.out_trim      <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_CROSS:    prdata = {16'd0, cfg_reg.cross_gain};
            REG_ROOM:     prdata = {16'd0, cfg_reg.room_gain};
            REG_WIDTH:    prdata = {16'd0, cfg_reg.width_gain};
            REG_FEEDBACK: prdata = {17'd0, cfg_reg.feedback_gain};
            REG_SHADOW:   prdata = {16'd0, cfg_reg.shadow_coef};
            REG_DAMP:     prdata = {16'd0, cfg_reg.damp_coef};
            REG_TRIM:     prdata = {15'd0, cfg_reg.out_trim};
            default:      prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/shcr_store.sv */
// one channel delay store: synchronous memory, one port, registered read
`timescale 1ns / 1ps
`default_nettype none
module shcr_store #(
    parameter int DEPTH = 8192,
    parameter int DW    = 28
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [DW-1:0]            wdata,
    output logic      [DW-1:0]            rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* rtl/shcr_core.sv */
// sequencer and datapath: store access, filters, mixing, widening, trim
`timescale 1ns / 1ps
`default_nettype none
module shcr_core
    import shcr_pkg::*;
#(
    parameter int BUF_DEPTH       = 8192,
    parameter int CROSS_DELAY     = 14,
    parameter int TAP_ONE_DELAY   = 432,
    parameter int TAP_TWO_DELAY   = 816,
    parameter int TAP_THREE_DELAY = 1392,
    parameter int SAMPLE_BITS     = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire shcr_cfg_t              cfg,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] in_l,
    input  wire logic [SAMPLE_BITS-1:0] in_r,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [SAMPLE_BITS-1:0] out_l,
    output logic      [SAMPLE_BITS-1:0] out_r
);
    localparam int SW = SAMPLE_BITS + 4;
    localparam int AW = $clog2(BUF_DEPTH);
    localparam int AC = 64;
    localparam logic [AW-1:0] DC = AW'(CROSS_DELAY % BUF_DEPTH);
    localparam logic [AW-1:0] D1 = AW'(TAP_ONE_DELAY % BUF_DEPTH);
    localparam logic [AW-1:0] D2 = AW'(TAP_TWO_DELAY % BUF_DEPTH);
    localparam logic [AW-1:0] D3 = AW'(TAP_THREE_DELAY % BUF_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(BUF_DEPTH);
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] OMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_WR, S_RC, S_R1, S_R2, S_R3, S_SHL, S_SHR,
        S_ROOM, S_FBG, S_FBL, S_FBR, S_MIX, S_WIDE, S_TRIM, S_OUT
    } state_t;

    state_t state_reg;
    logic [AW:0] clr_reg;
    logic [AW-1:0] wp_reg;
    logic signed [SW-1:0] l_reg, r_reg;
    logic signed [SW-1:0] shl_reg, shr_reg, fbl_reg, fbr_reg;
    logic signed [SW-1:0] xl_reg, xr_reg;
    logic signed [SW-1:0] t1l_reg, t1r_reg, t2l_reg, t2r_reg;
    logic signed [AC-1:0] rl_reg, rr_reg;
    logic signed [AC-1:0] ml_reg, mr_reg, wl_reg, wr_reg;
    logic signed [AC-1:0] tl_reg, tr_reg;
    logic out_valid_reg;
    logic [SAMPLE_BITS-1:0] ol_reg, or_reg;

    logic we;
    logic [AW-1:0] addr;
    logic signed [SW-1:0] wdl, wdr, rdl, rdr;

    function automatic logic [AW-1:0] back(input logic [AW-1:0] w, input logic [AW-1:0] d);
        logic [AW:0] t;
        begin
            t = {1'b0, w} + DEPTH_W - {1'b0, d};
            if (t >= DEPTH_W)
                t = t - DEPTH_W;
            back = t[AW-1:0];
        end
    endfunction

    function automatic logic signed [AC-1:0] rnd(input logic signed [AC-1:0] x,
                                                input int s);
        rnd = (x + (AC'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [SW-1:0] sats(input logic signed [AC-1:0] x);
        if (x > AC'(SMAX))
            sats = SMAX;
        else if (x < AC'(SMIN))
            sats = SMIN;
        else
            sats = x[SW-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sato(input logic signed [AC-1:0] x);
        if (x > AC'(OMAX))
            sato = OMAX;
        else if (x < AC'(OMIN))
            sato = OMIN;
        else
            sato = x[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [SW-1:0] pole(input logic signed [SW-1:0] acc,
                                                 input logic signed [AC-1:0] x,
                                                 input logic [15:0] coef);
        logic signed [AC-1:0] p;
        begin
            p = $signed({1'b0, coef}) * (x - AC'(acc));
            pole = sats(AC'(acc) + rnd(p, 16));
        end
    endfunction

    always_comb
    begin
        we = 1'b0;
        addr = wp_reg;
        wdl = sats(AC'(l_reg) + AC'(fbl_reg));
        wdr = sats(AC'(r_reg) + AC'(fbr_reg));
        case (state_reg)
            S_CLR:
            begin
                we = 1'b1;
                addr = clr_reg[AW-1:0];
                wdl = '0;
                wdr = '0;
            end
            S_WR: we = 1'b1;
            S_RC: addr = back(wp_reg, DC);
            S_R1: addr = back(wp_reg, D1);
            S_R2: addr = back(wp_reg, D2);
            S_R3: addr = back(wp_reg, D3);
            default: addr = wp_reg;
        endcase
    end

    shcr_store #(.DEPTH(BUF_DEPTH), .DW(SW)) u_store_l (
        .clk(clk), .we(we), .addr(addr), .wdata(wdl), .rdata(rdl));
    shcr_store #(.DEPTH(BUF_DEPTH), .DW(SW)) u_store_r (
        .clk(clk), .we(we), .addr(addr), .wdata(wdr), .rdata(rdr));

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_l     = ol_reg;
    assign out_r     = or_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            wp_reg <= '0;
            shl_reg <= '0;
            shr_reg <= '0;
            fbl_reg <= '0;
            fbr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == DEPTH_W - 1'b1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        l_reg <= SW'($signed(in_l));
                        r_reg <= SW'($signed(in_r));
                        state_reg <= S_WR;
                    end
                end
                S_WR: state_reg <= S_RC;
                S_RC: state_reg <= S_R1;
                S_R1:
                begin
                    xl_reg <= rdl;
                    xr_reg <= rdr;
                    state_reg <= S_R2;
                end
                S_R2:
                begin
                    t1l_reg <= rdl;
                    t1r_reg <= rdr;
                    state_reg <= S_R3;
                end
                S_R3:
                begin
                    t2l_reg <= rdl;
                    t2r_reg <= rdr;
                    state_reg <= S_SHL;
                end
                S_SHL:
                begin
                    // tap three data arrives here
                    rl_reg <= AC'(t1l_reg) * W_TAP_ONE + AC'(t2r_reg) * W_TAP_TWO
                              + AC'(rdl) * W_TAP_THREE;
                    rr_reg <= AC'(t1r_reg) * W_TAP_ONE + AC'(t2l_reg) * W_TAP_TWO
                              + AC'(rdr) * W_TAP_THREE;
                    shl_reg <= pole(shl_reg, AC'(xr_reg), cfg.shadow_coef);
                    state_reg <= S_SHR;
                end
                S_SHR:
                begin
                    shr_reg <= pole(shr_reg, AC'(xl_reg), cfg.shadow_coef);
                    state_reg <= S_ROOM;
                end
                S_ROOM:
                begin
                    rl_reg <= rnd(rl_reg, 16);
                    rr_reg <= rnd(rr_reg, 16);
                    state_reg <= S_FBG;
                end
                S_FBG:
                begin
                    tl_reg <= rnd(rl_reg * $signed({1'b0, cfg.feedback_gain}), 16);
                    tr_reg <= rnd(rr_reg * $signed({1'b0, cfg.feedback_gain}), 16);
                    state_reg <= S_FBL;
                end
                S_FBL:
                begin
                    fbl_reg <= pole(fbl_reg, tl_reg, cfg.damp_coef);
                    state_reg <= S_FBR;
                end
                S_FBR:
                begin
                    fbr_reg <= pole(fbr_reg, tr_reg, cfg.damp_coef);
                    state_reg <= S_MIX;
                end
                S_MIX:
                begin
                    ml_reg <= rnd((AC'(l_reg) <<< 16)
                        + $signed({1'b0, cfg.cross_gain}) * AC'(shl_reg)
                        + $signed({1'b0, cfg.room_gain}) * rl_reg, 16);
                    mr_reg <= rnd((AC'(r_reg) <<< 16)
                        + $signed({1'b0, cfg.cross_gain}) * AC'(shr_reg)
                        + $signed({1'b0, cfg.room_gain}) * rr_reg, 16);
                    state_reg <= S_WIDE;
                end
                S_WIDE:
                begin
                    wl_reg <= rnd(((ml_reg + mr_reg) <<< 14)
                        + (ml_reg - mr_reg) * $signed({1'b0, cfg.width_gain}), 15);
                    wr_reg <= rnd(((ml_reg + mr_reg) <<< 14)
                        - (ml_reg - mr_reg) * $signed({1'b0, cfg.width_gain}), 15);
                    state_reg <= S_TRIM;
                end
                S_TRIM:
                begin
                    tl_reg <= rnd(wl_reg * $signed({1'b0, cfg.out_trim}), 16);
                    tr_reg <= rnd(wr_reg * $signed({1'b0, cfg.out_trim}), 16);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        ol_reg <= sato(tl_reg);
                        or_reg <= sato(tr_reg);
                        out_valid_reg <= 1'b1;
                        wp_reg <= (wp_reg == AW'(BUF_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/stereo_headphone_crossfeed_reverb.sv */
// top level of the headphone crossfeed and early reflection block
`timescale 1ns / 1ps
`default_nettype none
// one stereo pair in, one processed pair out. a pair is accepted only in idle and
// the block takes no new pair before its result is offered: a sequencer walks one
// write and four reads through the single-port delay memories, then the filter,
// mix, widening and trim steps. a result held by the receiver holds off the next pair.
// after reset a clearing pass over all BUF_DEPTH entries zeroes the delay memories
// before the first pair is taken; configuration writes are taken throughout.
module stereo_headphone_crossfeed_reverb
    import shcr_pkg::*;
#(
    parameter int BUF_DEPTH       = 8192,
    parameter int CROSS_DELAY     = 14,
    parameter int TAP_ONE_DELAY   = 432,
    parameter int TAP_TWO_DELAY   = 816,
    parameter int TAP_THREE_DELAY = 1392,
    parameter int SAMPLE_BITS     = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // left_in, right_in from bit 0 up
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // left_out, right_out from bit 0 up
    output logic      [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [4:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);
    localparam int TW = ((2*SAMPLE_BITS+7)/8)*8;

    shcr_cfg_t cfg;
    logic [SAMPLE_BITS-1:0] out_l, out_r;

    assign pready = 1'b1;

    shcr_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg));

    shcr_core #(
        .BUF_DEPTH(BUF_DEPTH), .CROSS_DELAY(CROSS_DELAY), .TAP_ONE_DELAY(TAP_ONE_DELAY),
        .TAP_TWO_DELAY(TAP_TWO_DELAY), .TAP_THREE_DELAY(TAP_THREE_DELAY),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_l(s_tdata[SAMPLE_BITS-1:0]), .in_r(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_l(out_l), .out_r(out_r));

    // result pair packed with zero fill up to whole bytes
    assign m_tdata = TW'({out_r, out_l});
endmodule
`default_nettype wire

/* rtl/shcr_checker.sv */
// port-level checker for the crossfeed block and its bind
`timescale 1ns / 1ps
`default_nettype none
module shcr_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic pready
);
    // one pair at a time: no new transaction the cycle after one is taken
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken back to back");
    // no result right after an input transaction
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result too early");
    // result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind stereo_headphone_crossfeed_reverb shcr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .pready(pready));
`default_nettype wire
